/* design/wshc_pkg.sv */
// ----------------------------------------------------------------------------
// wshc_pkg
// Shared types and constants of the window size hint constraint unit.
// ----------------------------------------------------------------------------
package wshc_pkg;

    localparam int HintValBits = 24;
    localparam int ReqBits     = 16;
    localparam int InDataBits  = 96;
    localparam int AddrBits    = 5;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SCREEN_W  = 3'd0,
        REG_SCREEN_H  = 3'd1,
        REG_BAR_H     = 3'd2,
        REG_AREA_L    = 3'd3,
        REG_AREA_T    = 3'd4,
        REG_AREA_W    = 3'd5,
        REG_AREA_H    = 3'd6,
        REG_HINTS_ALW = 3'd7
    } t_reg_idx;

    // Hint word selects.
    typedef enum logic [3:0] {
        HW_BASE_W = 4'd0,  HW_BASE_H = 4'd1,  HW_MIN_W  = 4'd2,  HW_MIN_H  = 4'd3,
        HW_INC_W  = 4'd4,  HW_INC_H  = 4'd5,  HW_MAX_W  = 4'd6,  HW_MAX_H  = 4'd7,
        HW_MIN_AS = 4'd8,  HW_MAX_AS = 4'd9,  HW_BORDER = 4'd10, HW_FLOAT  = 4'd11,
        HW_CUR_X  = 4'd12, HW_CUR_Y  = 4'd13, HW_CUR_W  = 4'd14, HW_CUR_H  = 4'd15
    } t_hint_sel;

    typedef enum logic {
        OP_HINT      = 1'b0,
        OP_CONSTRAIN = 1'b1
    } t_op;

    // Datapath commands.
    typedef enum logic [3:0] {
        CMD_NONE, CMD_HINT, CMD_LOAD, CMD_EDGE, CMD_A1M, CMD_A1C, CMD_A2M, CMD_A2C,
        CMD_BASE, CMD_DLW, CMD_DLH, CMD_DSTEP, CMD_DENDW, CMD_DENDH, CMD_FIN
    } t_cmd;

    typedef struct packed {
        logic               hints_on;
        logic               aspect_on;
        logic               below;
        logic               out_free;
    } t_status;

    typedef struct packed {
        logic [14:0]        screen_w;
        logic [14:0]        screen_h;
        logic [9:0]         bar_h;
        logic signed [15:0] area_l;
        logic signed [15:0] area_t;
        logic [14:0]        area_w;
        logic [14:0]        area_h;
        logic               hints_always;
    } t_cfg;

endpackage

/* design/wshc_ctrl.sv */
// ----------------------------------------------------------------------------
// wshc_ctrl
// Sequencer: takes hint writes while idle and steps the datapath through one constrain request.
// ----------------------------------------------------------------------------
module wshc_ctrl
    import wshc_pkg::*;
#(
    parameter int STEPS = 40
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_op,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int CntBits = $clog2(STEPS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE, ST_A1M, ST_A1C, ST_A2M, ST_A2C, ST_BASE,
        ST_DLW, ST_DSW, ST_DEW, ST_DLH, ST_DSH, ST_DEH, ST_FIN
    } t_state;

    t_state               r_state, n_state;
    logic [CntBits-1:0]   r_cnt, n_cnt;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = CMD_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_CONSTRAIN) begin
                        o_cmd   = CMD_LOAD;
                        n_state = ST_EDGE;
                    end else begin
                        o_cmd = CMD_HINT;
                    end
                end
            end
            ST_EDGE: begin
                o_cmd = CMD_EDGE;
                if (!i_status.hints_on) n_state = ST_FIN;
                else if (i_status.aspect_on) n_state = ST_A1M;
                else n_state = ST_BASE;
            end
            ST_A1M: begin
                o_cmd   = CMD_A1M;
                n_state = ST_A1C;
            end
            ST_A1C: begin
                o_cmd   = CMD_A1C;
                n_state = i_status.below ? ST_BASE : ST_A2M;
            end
            ST_A2M: begin
                o_cmd   = CMD_A2M;
                n_state = ST_A2C;
            end
            ST_A2C: begin
                o_cmd   = CMD_A2C;
                n_state = ST_BASE;
            end
            ST_BASE: begin
                o_cmd   = CMD_BASE;
                n_state = ST_DLW;
            end
            ST_DLW: begin
                o_cmd   = CMD_DLW;
                n_cnt   = CntBits'(STEPS - 1);
                n_state = ST_DSW;
            end
            ST_DSW: begin
                o_cmd = CMD_DSTEP;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = ST_DEW;
            end
            ST_DEW: begin
                o_cmd   = CMD_DENDW;
                n_state = ST_DLH;
            end
            ST_DLH: begin
                o_cmd   = CMD_DLH;
                n_cnt   = CntBits'(STEPS - 1);
                n_state = ST_DSH;
            end
            ST_DSH: begin
                o_cmd = CMD_DSTEP;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = ST_DEH;
            end
            ST_DEH: begin
                o_cmd   = CMD_DENDH;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd   = CMD_FIN;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* design/wshc_dp.sv */
// ----------------------------------------------------------------------------
// wshc_dp
// Datapath: hint registers, geometry arithmetic, shared multiplier and
// bit-serial remainder unit, result register.
// ----------------------------------------------------------------------------
module wshc_dp
    import wshc_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int ASPECT_FRAC_BITS = 16,
    parameter int WB               = 20,
    parameter int PW               = 44
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  t_cmd                         i_cmd,
    input  logic [3:0]                   i_hint_sel,
    input  logic signed [HintValBits-1:0] i_hint_val,
    input  logic signed [ReqBits-1:0]    i_req_x,
    input  logic signed [ReqBits-1:0]    i_req_y,
    input  logic signed [ReqBits-1:0]    i_req_w,
    input  logic signed [ReqBits-1:0]    i_req_h,
    input  logic                         i_inter,
    output t_status                      o_status,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_w,
    output logic signed [COORD_BITS-1:0] o_h,
    output logic                         o_changed
);

    localparam int C  = COORD_BITS;
    localparam int F  = ASPECT_FRAC_BITS;
    localparam int DR = C + 1;

    logic signed [C-1:0] r_base_w, r_base_h, r_min_w, r_min_h, r_inc_w, r_inc_h;
    logic signed [C-1:0] r_max_w, r_max_h, r_border, r_cur_x, r_cur_y, r_cur_w, r_cur_h;
    logic signed [HintValBits-1:0] r_min_as, r_max_as;
    logic r_float;

    logic signed [WB-1:0] r_x, r_y;
    logic signed [PW-1:0] r_w, r_h, r_prod;
    logic                 r_inter;
    logic [PW-1:0]        r_dq;
    logic [DR-1:0]        r_rem;
    logic [C-1:0]         r_div;
    logic                 r_neg;

    logic signed [HintValBits+C-1:0] hint_wide;
    logic signed [C-1:0]  hint_c;
    assign hint_wide = (HintValBits+C)'(i_hint_val);
    assign hint_c    = hint_wide[C-1:0];

    // status
    logic hints_on, aspect_on, base_is_min;
    assign hints_on    = i_cfg.hints_always | r_float;
    assign aspect_on   = (r_min_as > 0) && (r_max_as > 0);
    assign base_is_min = (r_base_w == r_min_w) && (r_base_h == r_min_h);

    // common terms
    logic signed [WB-1:0] bw2, sw, sh, al, at, ar, ab, bar;
    assign bw2 = WB'(r_border) <<< 1;
    assign sw  = WB'($signed({1'b0, i_cfg.screen_w}));
    assign sh  = WB'($signed({1'b0, i_cfg.screen_h}));
    assign al  = WB'(i_cfg.area_l);
    assign at  = WB'(i_cfg.area_t);
    assign ar  = al + WB'($signed({1'b0, i_cfg.area_w}));
    assign ab  = at + WB'($signed({1'b0, i_cfg.area_h}));
    assign bar = WB'($signed({1'b0, i_cfg.bar_h}));

    // load: clamp size to one, pull back from the far edge
    logic signed [WB-1:0] lx, ly, lw, lh, ld_x, ld_y;
    always_comb begin
        lx = WB'(i_req_x);
        ly = WB'(i_req_y);
        lw = (i_req_w < 1) ? WB'(1) : WB'(i_req_w);
        lh = (i_req_h < 1) ? WB'(1) : WB'(i_req_h);
        ld_x = lx;
        ld_y = ly;
        if (i_inter) begin
            if (lx > sw) ld_x = sw - (WB'(r_cur_w) + bw2);
            if (ly > sh) ld_y = sh - (WB'(r_cur_h) + bw2);
        end else begin
            if (lx >= ar) ld_x = ar - (WB'(r_cur_w) + bw2);
            if (ly >= ab) ld_y = ab - (WB'(r_cur_h) + bw2);
        end
    end

    // edge: pull back from the near edge, raise to bar height, early base
    logic signed [WB-1:0] tx, ty, ed_x, ed_y;
    logic signed [PW-1:0] ed_w, ed_h;
    always_comb begin
        tx = r_x + r_w[WB-1:0] + bw2;
        ty = r_y + r_h[WB-1:0] + bw2;
        ed_x = r_x;
        ed_y = r_y;
        if (r_inter) begin
            if (tx < 0) ed_x = '0;
            if (ty < 0) ed_y = '0;
        end else begin
            if (tx <= al) ed_x = al;
            if (ty <= at) ed_y = at;
        end
        ed_w = (r_w < PW'(bar)) ? PW'(bar) : r_w;
        ed_h = (r_h < PW'(bar)) ? PW'(bar) : r_h;
        if (hints_on && !base_is_min) begin
            ed_w = ed_w - PW'(r_base_w);
            ed_h = ed_h - PW'(r_base_h);
        end
    end

    // multiplier operands
    logic signed [WB-1:0]          m_a;
    logic signed [HintValBits-1:0] m_q;
    assign m_a = (i_cmd == CMD_A1M) ? r_h[WB-1:0] : r_w[WB-1:0];
    assign m_q = (i_cmd == CMD_A1M) ? r_max_as : r_min_as;

    // ratio test and rounding on the stored product
    logic signed [PW-1:0] num, den, scaled, rnd;
    logic signed [PW:0]   nr;
    logic                 below;
    always_comb begin
        num = (i_cmd == CMD_A2C) ? r_h : r_w;
        den = (i_cmd == CMD_A2C) ? r_w : r_h;
        scaled = num <<< F;
        if (den == 0) below = (num > 0);
        else if (den > 0) below = (r_prod < scaled);
        else below = (r_prod > scaled);
        nr = (PW+1)'(r_prod) + ((PW+1)'(1) <<< (F-1));
        if (nr < 0) nr = nr + (((PW+1)'(1) <<< F) - (PW+1)'(1));
        nr  = nr >>> F;
        rnd = nr[PW-1:0];
    end

    // remainder unit
    logic [DR-1:0] dtry;
    logic [DR-1:0] dnext;
    logic signed [PW-1:0] dsrc, remv, inc_sel, base_sel;
    logic signed [C-1:0]  inc_src;
    always_comb begin
        dtry    = {r_rem[DR-2:0], r_dq[PW-1]};
        dnext   = (dtry >= {1'b0, r_div}) ? dtry - {1'b0, r_div} : dtry;
        dsrc    = (i_cmd == CMD_DLH) ? r_h : r_w;
        inc_src = (i_cmd == CMD_DLH) ? r_inc_h : r_inc_w;
        remv    = PW'($signed({1'b0, r_rem[C-1:0]}));
        if (r_neg) remv = -remv;
        inc_sel  = (i_cmd == CMD_DENDH) ? PW'(r_inc_h) : PW'(r_inc_w);
        base_sel = (i_cmd == CMD_DENDH) ? PW'(r_base_h) : PW'(r_base_w);
    end

    // final min / max and saturation
    localparam logic signed [PW-1:0] SatHi = (PW'(1) <<< (C-1)) - PW'(1);
    localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);
    logic signed [PW-1:0] fw, fh;
    logic signed [C-1:0]  sx, sy, sw_o, sh_o;
    always_comb begin
        fw = r_w;
        fh = r_h;
        if (hints_on) begin
            if (fw < PW'(r_min_w)) fw = PW'(r_min_w);
            if (fh < PW'(r_min_h)) fh = PW'(r_min_h);
            if (r_max_w != 0 && fw > PW'(r_max_w)) fw = PW'(r_max_w);
            if (r_max_h != 0 && fh > PW'(r_max_h)) fh = PW'(r_max_h);
        end
        sx   = (PW'(r_x) > SatHi) ? SatHi[C-1:0] :
               (PW'(r_x) < SatLo) ? SatLo[C-1:0] : C'(r_x);
        sy   = (PW'(r_y) > SatHi) ? SatHi[C-1:0] :
               (PW'(r_y) < SatLo) ? SatLo[C-1:0] : C'(r_y);
        sw_o = (fw > SatHi) ? SatHi[C-1:0] : (fw < SatLo) ? SatLo[C-1:0] : fw[C-1:0];
        sh_o = (fh > SatHi) ? SatHi[C-1:0] : (fh < SatLo) ? SatLo[C-1:0] : fh[C-1:0];
    end

    assign o_status = '{hints_on: hints_on, aspect_on: aspect_on, below: below,
                        out_free: (!o_valid || i_ready)};

    // hint words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_w <= '0; r_base_h <= '0; r_min_w <= '0; r_min_h <= '0;
            r_inc_w  <= '0; r_inc_h  <= '0; r_max_w <= '0; r_max_h <= '0;
            r_min_as <= '0; r_max_as <= '0; r_border <= '0; r_float <= 1'b0;
            r_cur_x  <= '0; r_cur_y  <= '0; r_cur_w <= '0; r_cur_h <= '0;
        end else if (i_cmd == CMD_HINT) begin
            case (t_hint_sel'(i_hint_sel))
                HW_BASE_W: r_base_w <= hint_c;
                HW_BASE_H: r_base_h <= hint_c;
                HW_MIN_W:  r_min_w  <= hint_c;
                HW_MIN_H:  r_min_h  <= hint_c;
                HW_INC_W:  r_inc_w  <= hint_c;
                HW_INC_H:  r_inc_h  <= hint_c;
                HW_MAX_W:  r_max_w  <= hint_c;
                HW_MAX_H:  r_max_h  <= hint_c;
                HW_MIN_AS: r_min_as <= i_hint_val;
                HW_MAX_AS: r_max_as <= i_hint_val;
                HW_BORDER: r_border <= hint_c;
                HW_FLOAT:  r_float  <= i_hint_val[0];
                HW_CUR_X:  r_cur_x  <= hint_c;
                HW_CUR_Y:  r_cur_y  <= hint_c;
                HW_CUR_W:  r_cur_w  <= hint_c;
                default:   r_cur_h  <= hint_c;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_x     <= ld_x;
                r_y     <= ld_y;
                r_w     <= PW'(lw);
                r_h     <= PW'(lh);
                r_inter <= i_inter;
            end
            CMD_EDGE: begin
                r_x <= ed_x;
                r_y <= ed_y;
                r_w <= ed_w;
                r_h <= ed_h;
            end
            CMD_A1M, CMD_A2M: r_prod <= PW'(m_a * m_q);
            CMD_A1C: if (below) r_w <= rnd;
            CMD_A2C: if (below) r_h <= rnd;
            CMD_BASE: begin
                if (base_is_min) begin
                    r_w <= r_w - PW'(r_base_w);
                    r_h <= r_h - PW'(r_base_h);
                end
            end
            CMD_DLW, CMD_DLH: begin
                r_dq  <= (dsrc < 0) ? -dsrc : dsrc;
                r_neg <= (dsrc < 0);
                r_rem <= '0;
                r_div <= (inc_src < 0) ? -inc_src : inc_src;
            end
            CMD_DSTEP: begin
                r_rem <= dnext;
                r_dq  <= {r_dq[PW-2:0], 1'b0};
            end
            CMD_DENDW: r_w <= ((inc_sel != 0) ? r_w - remv : r_w) + base_sel;
            CMD_DENDH: r_h <= ((inc_sel != 0) ? r_h - remv : r_h) + base_sel;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd == CMD_FIN) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
        if (i_cmd == CMD_FIN) begin
            o_x       <= sx;
            o_y       <= sy;
            o_w       <= sw_o;
            o_h       <= sh_o;
            o_changed <= (sx != r_cur_x) || (sy != r_cur_y) ||
                         (sw_o != r_cur_w) || (sh_o != r_cur_h);
        end
    end

endmodule

/* design/window_size_hint_constrain.sv */
// ----------------------------------------------------------------------------
// window_size_hint_constrain
// Constrains requested window rectangles against one window's size hints.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser selects the kind: a hint
//   write loads one hint word (size hints or current geometry) and returns
//   nothing; a constrain request returns one rectangle plus a changed flag
//   on the m_axis channel.
//   A hint write is taken while idle. A constrain request steps through
//   load, edge and finish when no hints apply; else it also runs the
//   aspect steps when the aspect limits are in force, the base step and
//   the bit-serial remainder unit, which works PW dividend bits (PW =
//   max(COORD_BITS, 16) + 28) one dividend bit a cycle, once for width
//   and once for height.
//   One request is in work at a time; s_axis_tready is high while idle.
//   A finished result waits in the output register; the next request is
//   accepted meanwhile and holds in its last step until the receiver takes
//   the previous result.
//   Screen, bar and work area settings sit in APB registers; write them
//   only while idle. Reset restores the register defaults and clears all
//   hint words.
// ----------------------------------------------------------------------------
module window_size_hint_constrain
    import wshc_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int ASPECT_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // s_axis_tdata: hint_select[3:0], hint_value[27:4], request_x[43:28],
    // request_y[59:44], request_width[75:60], request_height[91:76],
    // interactive[92], zero pad
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [InDataBits-1:0]  s_axis_tdata,
    // s_axis_tuser: operation
    input  logic                   s_axis_tuser,
    // m_axis_tdata: result_x, result_y, result_width, result_height
    // (COORD_BITS each), changed, zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [((4*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [AddrBits-1:0]    paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int C   = COORD_BITS;
    localparam int WB  = ((C > 16) ? C : 16) + 4;   // pre-hint geometry
    localparam int PW  = WB + HintValBits;          // product and hint math
    localparam int ODW = ((4*C+1+7)/8)*8;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    logic signed [C-1:0] res_x, res_y, res_w, res_h;
    logic                res_changed;

    // APB register file; always ready
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_w     <= 15'd1920;
            r_cfg.screen_h     <= 15'd1080;
            r_cfg.bar_h        <= 10'd20;
            r_cfg.area_l       <= '0;
            r_cfg.area_t       <= '0;
            r_cfg.area_w       <= 15'd1920;
            r_cfg.area_h       <= 15'd1060;
            r_cfg.hints_always <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_SCREEN_W: r_cfg.screen_w <= pwdata[14:0];
                REG_SCREEN_H: r_cfg.screen_h <= pwdata[14:0];
                REG_BAR_H:    r_cfg.bar_h    <= pwdata[9:0];
                REG_AREA_L:   r_cfg.area_l   <= $signed(pwdata[15:0]);
                REG_AREA_T:   r_cfg.area_t   <= $signed(pwdata[15:0]);
                REG_AREA_W:   r_cfg.area_w   <= pwdata[14:0];
                REG_AREA_H:   r_cfg.area_h   <= pwdata[14:0];
                default:      r_cfg.hints_always <= pwdata[0];
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_SCREEN_W: prdata = {17'd0, r_cfg.screen_w};
            REG_SCREEN_H: prdata = {17'd0, r_cfg.screen_h};
            REG_BAR_H:    prdata = {22'd0, r_cfg.bar_h};
            REG_AREA_L:   prdata = {16'd0, r_cfg.area_l};
            REG_AREA_T:   prdata = {16'd0, r_cfg.area_t};
            REG_AREA_W:   prdata = {17'd0, r_cfg.area_w};
            REG_AREA_H:   prdata = {17'd0, r_cfg.area_h};
            default:      prdata = {31'd0, r_cfg.hints_always};
        endcase
    end

    // sequencer
    wshc_ctrl #(
        .STEPS (PW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath
    wshc_dp #(
        .COORD_BITS       (COORD_BITS),
        .ASPECT_FRAC_BITS (ASPECT_FRAC_BITS),
        .WB               (WB),
        .PW               (PW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .i_hint_sel (s_axis_tdata[3:0]),
        .i_hint_val ($signed(s_axis_tdata[27:4])),
        .i_req_x    ($signed(s_axis_tdata[43:28])),
        .i_req_y    ($signed(s_axis_tdata[59:44])),
        .i_req_w    ($signed(s_axis_tdata[75:60])),
        .i_req_h    ($signed(s_axis_tdata[91:76])),
        .i_inter    (s_axis_tdata[92]),
        .o_status   (status),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_x        (res_x),
        .o_y        (res_y),
        .o_w        (res_w),
        .o_h        (res_h),
        .o_changed  (res_changed)
    );

    // pack the result, lowest field first
    assign m_axis_tdata = ODW'({res_changed, res_h, res_w, res_y, res_x});

endmodule
